// File: src/rtme_pkg.sv
package rtme_pkg;

    localparam int PROG_DEPTH_DEF  = 512;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int OPCODE_BITS     = 3;
    localparam int WORD_BITS       = 16;
    localparam int OPERAND_BITS    = WORD_BITS - OPCODE_BITS;
    localparam int ADDR_BITS       = 9;
    localparam int SYM_BITS        = 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_CHAR  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_RUN      = 2'd0,
        STAT_MATCH    = 2'd1,
        STAT_NOMATCH  = 2'd2,
        STAT_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [OPCODE_BITS-1:0] {
        OPC_ACCEPT = 3'd0,
        OPC_SPLIT  = 3'd1,
        OPC_MATCH  = 3'd2,
        OPC_JUMP   = 3'd3,
        OPC_FAIL   = 3'd4,
        OPC_ANY    = 3'd5,
        OPC_PART   = 3'd6,
        OPC_NOT    = 3'd7
    } t_opcode;

endpackage

// File: src/regex_thread_match_engine.sv
// Start, no-op and finished-match items answer in the cycle after acceptance; a load passes
// through S_LOAD and S_LDWR (its jump target is reduced modulo the program depth by a
// reciprocal multiply). A character runs steps of FETCH, PROG, EXEC and SPLIT; a step fetches
// one thread or waits out the pipeline; a watchdog caps steps at 4*PROGRAM_DEPTH*QUEUE_DEPTH.
// Throughput: one item at a time, busy stays high until o_done; the receiver cannot stall.
// Reset (synchronous, active low) empties both queues and clears status; program memory keeps.
module regex_thread_match_engine #(
    parameter int PROGRAM_DEPTH = rtme_pkg::PROG_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = rtme_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_op,
    input  logic [rtme_pkg::ADDR_BITS-1:0]  i_prog_addr,
    input  logic [rtme_pkg::WORD_BITS-1:0]  i_prog_word,
    input  logic [rtme_pkg::SYM_BITS-1:0]   i_symbol,
    input  logic                            i_is_end,
    output logic                            o_done,
    output logic [1:0]                      o_status
);
    import rtme_pkg::*;

    localparam int PA_W      = $clog2(PROGRAM_DEPTH);
    localparam int QI        = $clog2(QUEUE_DEPTH);
    localparam int QC        = $clog2(QUEUE_DEPTH + 1);
    localparam int CYC_LIMIT = 4 * PROGRAM_DEPTH * QUEUE_DEPTH;
    localparam int CYC_W     = $clog2(CYC_LIMIT + 1);
    localparam int ENT_W     = PA_W + WORD_BITS;
    localparam int CMP_W     = (PA_W + 1 > ADDR_BITS) ? PA_W + 1 : ADDR_BITS;
    localparam int QM_DEPTH  = 2 ** (QI + 1);
    localparam int RECIP_SH  = OPERAND_BITS + PA_W;
    localparam int RECIP     = (2 ** RECIP_SH + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;
    localparam int PROD_W    = 2 * OPERAND_BITS + 2;

    // One pipeline step spans four states:
    //   FETCH  issue queue read at the head of the active queue, run the watchdog
    //   PROG   issue program read at the head PC
    //   EXEC   execute the previously fetched word, do its push
    //   SPLIT  push a pending split target, pop the head, swap or finish
    // Queue reads and writes never land in the same cycle, so the queue memory
    // needs no forwarding.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LDWR,
        S_FETCH,
        S_PROG,
        S_EXEC,
        S_SPLIT
    } t_state;

    t_state              r_state;
    logic                r_done;
    t_status             r_status;

    // queue pointers and fill counts, two ping-pong queues
    logic [QI-1:0]       r_head [2];
    logic [QC-1:0]       r_cnt  [2];
    logic                r_act;
    logic [CYC_W-1:0]    r_cyc;

    // stage 1 -> 2 (fetched word) and stage 2 -> 3 (split target)
    logic                r_f_valid;
    logic [PA_W-1:0]     r_f_pc;
    logic [WORD_BITS-1:0] r_f_word;
    logic [PA_W-1:0]     r_f_tgt;
    logic                r_s_valid;
    logic [PA_W-1:0]     r_s_tgt;

    // values being built during the current step
    logic                r_s1;
    logic [PA_W-1:0]     r_npc;
    logic [WORD_BITS-1:0] r_nword;
    logic [PA_W-1:0]     r_ntgt;
    logic                r_sn_valid;
    logic [PA_W-1:0]     r_sn_tgt;

    logic [SYM_BITS-1:0] r_ch;
    logic                r_end;

    // load path: operand reduced modulo the program depth
    logic [PA_W-1:0]     r_ld_addr;
    logic [WORD_BITS-1:0] r_ld_word;
    logic                r_ld_ok;
    logic [OPERAND_BITS-1:0] r_quot;

    // memories
    logic [PA_W-1:0]     r_qmem [0:QM_DEPTH-1];
    logic [PA_W-1:0]     r_qrd;
    logic [ENT_W-1:0]    r_pmem [0:PROGRAM_DEPTH-1];
    logic [ENT_W-1:0]    r_prd;

    logic                accept;
    logic [OPERAND_BITS-1:0] ld_operand;
    logic [PROD_W-1:0]   ld_prod;
    logic [OPERAND_BITS:0] ld_qd;
    logic [PA_W-1:0]     ld_rem;

    t_opcode             opc;
    logic [OPERAND_BITS-1:0] ex_data;
    logic [PA_W-1:0]     ex_nxt;
    logic                ex_push;
    logic                ex_q;
    logic [PA_W-1:0]     ex_val;
    logic                ex_term;
    t_status             ex_stat;

    logic                push_en;
    logic                push_q;
    logic [PA_W-1:0]     push_val;
    logic                push_full;
    logic [QI:0]         tail_sum;
    logic [QI-1:0]       tail;

    logic                q_we;
    logic [QI:0]         q_waddr;
    logic [PA_W-1:0]     q_wdata;
    logic                p_we;

    logic [QC-1:0]       sp_cnt_push;
    logic [QC-1:0]       sp_cnt_a;
    logic                sp_swap;
    logic [QI-1:0]       sp_head_nx;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;

    // reduce the operand: reciprocal multiply for the quotient, then subtract
    assign ld_operand = r_ld_word[OPERAND_BITS-1:0];
    assign ld_prod    = PROD_W'(ld_operand) * PROD_W'(RECIP);
    assign ld_qd      = (OPERAND_BITS + 1)'(r_quot) * (OPERAND_BITS + 1)'(PROGRAM_DEPTH);
    assign ld_rem     = PA_W'((OPERAND_BITS + 1)'(ld_operand) - ld_qd);

    // execute stage decode
    assign opc     = t_opcode'(r_f_word[WORD_BITS-1:OPERAND_BITS]);
    assign ex_data = r_f_word[OPERAND_BITS-1:0];
    assign ex_nxt  = (r_f_pc == PA_W'(PROGRAM_DEPTH - 1)) ? '0 : r_f_pc + PA_W'(1);

    always_comb begin
        ex_push = 1'b0;
        ex_q    = r_act;
        ex_val  = ex_nxt;
        ex_term = 1'b0;
        ex_stat = STAT_RUN;
        unique case (opc)
            OPC_ACCEPT: begin
                if (r_ch == '0) begin
                    ex_term = 1'b1;
                    ex_stat = STAT_MATCH;
                end
            end
            OPC_SPLIT: begin
                ex_push = 1'b1;
            end
            OPC_MATCH: begin
                ex_push = (ex_data[SYM_BITS-1:0] == r_ch);
                ex_q    = ~r_act;
            end
            OPC_JUMP: begin
                ex_push = 1'b1;
                ex_val  = r_f_tgt;
            end
            OPC_FAIL: begin
                ex_term = 1'b1;
                ex_stat = STAT_NOMATCH;
            end
            OPC_ANY: begin
                ex_push = 1'b1;
                ex_q    = ~r_act;
            end
            OPC_PART: begin
                ex_term = 1'b1;
                ex_stat = STAT_MATCH;
            end
            OPC_NOT: begin
                ex_push = (ex_data[SYM_BITS-1:0] != r_ch);
            end
            default: begin
                ex_push = 1'b0;
            end
        endcase
    end

    // shared push path: execute push in EXEC, split target in SPLIT
    assign push_en   = ((r_state == S_EXEC) && r_f_valid && !ex_term && ex_push) ||
                       ((r_state == S_SPLIT) && r_s_valid);
    assign push_q    = (r_state == S_EXEC) ? ex_q : r_act;
    assign push_val  = (r_state == S_EXEC) ? ex_val : r_s_tgt;
    assign push_full = (r_cnt[push_q] == QC'(QUEUE_DEPTH));
    assign tail_sum  = (QI + 1)'(r_head[push_q]) + (QI + 1)'(r_cnt[push_q]);
    assign tail      = (tail_sum >= (QI + 1)'(QUEUE_DEPTH))
                       ? QI'(tail_sum - (QI + 1)'(QUEUE_DEPTH)) : QI'(tail_sum);

    always_comb begin
        q_we    = 1'b0;
        q_waddr = {push_q, tail};
        q_wdata = push_val;
        if ((r_state == S_IDLE) && accept && (t_op'(i_op) == OP_START)) begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = '0;
        end else if (push_en && !push_full) begin
            q_we = 1'b1;
        end
    end

    assign p_we = (r_state == S_LDWR) && r_ld_ok;

    // step bookkeeping for the active queue: push, then pop or swap
    assign sp_cnt_push = r_cnt[r_act] + QC'(push_en);
    assign sp_cnt_a    = r_s1 ? sp_cnt_push - QC'(1) : sp_cnt_push;
    assign sp_swap     = !r_s1 && (sp_cnt_push == '0);
    assign sp_head_nx  = (r_head[r_act] == QI'(QUEUE_DEPTH - 1)) ? '0
                         : r_head[r_act] + QI'(1);

    // queue memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        if (r_state == S_FETCH) begin
            r_qrd <= r_qmem[{r_act, r_head[r_act]}];
        end
    end

    // program memory: word plus its reduced target
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[r_ld_addr] <= {ld_rem, r_ld_word};
        end
        if (r_state == S_PROG) begin
            r_prd <= r_pmem[r_qrd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_status   <= STAT_RUN;
            r_head[0]  <= '0;
            r_head[1]  <= '0;
            r_cnt[0]   <= '0;
            r_cnt[1]   <= '0;
            r_act      <= 1'b0;
            r_f_valid  <= 1'b0;
            r_s_valid  <= 1'b0;
            r_sn_valid <= 1'b0;
            r_s1       <= 1'b0;
            r_cyc      <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (t_op'(i_op))
                            OP_LOAD: begin
                                r_ld_addr <= PA_W'(i_prog_addr);
                                r_ld_word <= i_prog_word;
                                r_ld_ok   <= (CMP_W'(i_prog_addr) < CMP_W'(PROGRAM_DEPTH));
                                r_state   <= S_LOAD;
                            end
                            OP_START: begin
                                // drop all threads, seed PC 0
                                r_head[0] <= '0;
                                r_head[1] <= '0;
                                r_cnt[0]  <= QC'(1);
                                r_cnt[1]  <= '0;
                                r_act     <= 1'b0;
                                r_f_valid <= 1'b0;
                                r_s_valid <= 1'b0;
                                r_status  <= STAT_RUN;
                                r_done    <= 1'b1;
                            end
                            OP_CHAR: begin
                                if (r_status != STAT_RUN) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_ch    <= i_is_end ? '0 : i_symbol;
                                    r_end   <= i_is_end;
                                    r_cyc   <= '0;
                                    r_state <= S_FETCH;
                                end
                            end
                            OP_NONE: begin
                                r_done <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    // hold the quotient, the write follows next cycle
                    r_quot  <= OPERAND_BITS'(ld_prod >> RECIP_SH);
                    r_state <= S_LDWR;
                end
                S_LDWR: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FETCH: begin
                    // watchdog against endless epsilon loops
                    if (r_cyc == CYC_W'(CYC_LIMIT)) begin
                        r_status <= STAT_OVERFLOW;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cyc   <= r_cyc + CYC_W'(1);
                        r_s1    <= (r_cnt[r_act] != '0);
                        r_state <= S_PROG;
                    end
                end
                S_PROG: begin
                    r_npc   <= r_qrd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_nword    <= r_prd[WORD_BITS-1:0];
                    r_ntgt     <= r_prd[ENT_W-1:WORD_BITS];
                    r_sn_valid <= r_f_valid && (opc == OPC_SPLIT);
                    r_sn_tgt   <= r_f_tgt;
                    if (r_f_valid && ex_term) begin
                        r_status <= ex_stat;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (push_en && push_full) begin
                        r_status <= STAT_OVERFLOW;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        if (push_en) begin
                            r_cnt[push_q] <= r_cnt[push_q] + QC'(1);
                        end
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (push_en && push_full) begin
                        r_status <= STAT_OVERFLOW;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        // advance the pipeline
                        r_cnt[r_act] <= sp_cnt_a;
                        if (r_s1) begin
                            r_head[r_act] <= sp_head_nx;
                        end
                        if (sp_swap) begin
                            r_act <= ~r_act;
                        end
                        r_f_valid <= r_s1;
                        r_f_pc    <= r_npc;
                        r_f_word  <= r_nword;
                        r_f_tgt   <= r_ntgt;
                        r_s_valid <= r_sn_valid;
                        r_s_tgt   <= r_sn_tgt;
                        priority if (sp_swap && r_end) begin
                            r_status <= STAT_NOMATCH;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if ((sp_cnt_a == '0) && (r_cnt[~r_act] == '0) &&
                                     !r_s1 && !r_sn_valid) begin
                            r_status <= STAT_NOMATCH;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (sp_swap) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a start item answers next cycle with idle status
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_START)) |=> (o_done && (o_status == STAT_RUN)))
        else $error("start item did not answer with idle status");

    // a finished match holds its status through character items
    a_ended_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_CHAR) && (o_status != STAT_RUN))
        |=> (o_done && (o_status == $past(o_status))))
        else $error("ended match changed status");

    // fill counts stay within the queue depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= QC'(QUEUE_DEPTH)) && (r_cnt[1] <= QC'(QUEUE_DEPTH)))
        else $error("queue count above depth");

    // a result strobe leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule
